// ----- design/pic_pkg.sv -----
// shared constants, index maps and types of the point-in-triangle classifier
package pic_pkg;

  localparam int COORD_BITS_DEF = 16;

  // configuration register indexes
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_AX = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_AY = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BX = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_BY = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_CX = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_CY = 3'd5;
  localparam int NUM_REGS = 6;

  // coordinate differences
  localparam int D_PAX = 0;
  localparam int D_PAY = 1;
  localparam int D_PBX = 2;
  localparam int D_PBY = 3;
  localparam int D_PCX = 4;
  localparam int D_PCY = 5;
  localparam int D_BAX = 6;
  localparam int D_BAY = 7;
  localparam int D_CBX = 8;
  localparam int D_CBY = 9;
  localparam int D_ACX = 10;
  localparam int D_ACY = 11;
  localparam int NUM_DIFF = 12;

  // products: operand pairs, added or subtracted two by two in the next stage
  localparam int NUM_PROD = 20;
  localparam int PROD_A [NUM_PROD] = '{
    D_PAX, D_PAY,  // edge ab cross
    D_PBX, D_PBY,  // edge bc cross
    D_PCX, D_PCY,  // edge ca cross
    D_BAX, D_BAY,  // triangle area
    D_BAX, D_BAY,  // |ab|^2
    D_ACX, D_ACY,  // |ac|^2
    D_CBX, D_CBY,  // |bc|^2
    D_PAX, D_PAY,  // (p-a).(p-b)
    D_PAX, D_PAY,  // (p-a).(p-c)
    D_PBX, D_PBY   // (p-b).(p-c)
  };
  localparam int PROD_B [NUM_PROD] = '{
    D_BAY, D_BAX,
    D_CBY, D_CBX,
    D_ACY, D_ACX,
    D_ACY, D_ACX,
    D_BAX, D_BAY,
    D_ACX, D_ACY,
    D_CBX, D_CBY,
    D_PBX, D_PBY,
    D_PCX, D_PCY,
    D_PCX, D_PCY
  };

  // sums of product pairs
  localparam int S_C1  = 0;
  localparam int S_C2  = 1;
  localparam int S_C3  = 2;
  localparam int S_DG  = 3;
  localparam int S_LAB = 4;
  localparam int S_LAC = 5;
  localparam int S_LBC = 6;
  localparam int S_DAB = 7;
  localparam int S_DAC = 8;
  localparam int S_DBC = 9;
  localparam int NUM_SUM = 10;
  localparam logic SUM_SUB [NUM_SUM] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  typedef enum logic [1:0] {
    LOC_INSIDE  = 2'd0,
    LOC_BORDER  = 2'd1,
    LOC_OUTSIDE = 2'd2
  } pic_loc_e;

  // sign code of a cross product: {negative, zero}
  typedef struct packed {
    logic [2:0] cr_neg;   // edges ab, bc, ca
    logic [2:0] cr_zero;  // edges ab, bc, ca
    logic       degen;
    logic       ab_lt_ac;
    logic       ab_lt_bc;
    logic       ac_lt_bc;
    logic       dot_ab_le;
    logic       dot_ac_le;
    logic       dot_bc_le;
  } pic_flags_t;

endpackage

// ----- design/point_in_triangle_classifier_unit.sv -----
// top level of the point-in-triangle classifier: vertex registers and stage chain
//
//   port group  direction  handshake                payload
//   in          receive    in_valid_i / in_stall_o  point_x_i, point_y_i
//   out         send       out_valid_o / out_stall_i location_o
//   cfg         receive    cfg_we_i                 cfg_idx_i, cfg_data_i
//
// one point per cycle sustained while out_stall_i stays low; five register stages
// (differences, multiplies, sums, flags, location) lie between the inputs and out_valid_o
// each stage holds its beat under stall and takes a new one once empty or
// moving, so bubbles close up and in_stall_o rises only when all five are full
// reset clears the vertex registers to zero and empties every stage
module point_in_triangle_classifier_unit #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [COORD_BITS-1:0]            point_x_i,
  input  logic [COORD_BITS-1:0]            point_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       location_o,
  input  logic                             cfg_we_i,
  input  logic [pic_pkg::REG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]            cfg_data_i
);

  logic [pic_pkg::NUM_REGS-1:0][COORD_BITS-1:0] vtx_q;

  logic                                           diff_rdy, diff_vld;
  logic                                           prod_rdy, prod_vld;
  logic                                           sum_rdy, sum_vld;
  logic                                           class_rdy;
  logic [pic_pkg::NUM_DIFF-1:0][COORD_BITS:0]     diff;
  logic [pic_pkg::NUM_PROD-1:0][2*COORD_BITS+1:0] prod;
  logic [pic_pkg::NUM_SUM-1:0][2*COORD_BITS+2:0]  sum;

  // writes beyond the last vertex register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < pic_pkg::REG_IDX_BITS'(pic_pkg::NUM_REGS))) begin
      vtx_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  pic_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (diff_rdy),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .vtx_i     (vtx_q),
    .valid_o   (diff_vld),
    .ready_i   (prod_rdy),
    .diff_o    (diff)
  );

  pic_prod #(.COORD_BITS(COORD_BITS)) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_vld),
    .ready_o (prod_rdy),
    .diff_i  (diff),
    .valid_o (prod_vld),
    .ready_i (sum_rdy),
    .prod_o  (prod)
  );

  pic_sum #(.COORD_BITS(COORD_BITS)) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_vld),
    .ready_o (sum_rdy),
    .prod_i  (prod),
    .valid_o (sum_vld),
    .ready_i (class_rdy),
    .sum_o   (sum)
  );

  pic_class #(.COORD_BITS(COORD_BITS)) u_class (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (sum_vld),
    .ready_o    (class_rdy),
    .sum_i      (sum),
    .valid_o    (out_valid_o),
    .ready_i    (!out_stall_i),
    .location_o (location_o)
  );

  assign in_stall_o = !diff_rdy;

endmodule

// ----- design/pic_diff.sv -----
// stage one: sign-extended coordinate differences
module pic_diff #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [COORD_BITS-1:0]                            point_x_i,
  input  logic [COORD_BITS-1:0]                            point_y_i,
  input  logic [pic_pkg::NUM_REGS-1:0][COORD_BITS-1:0]     vtx_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [pic_pkg::NUM_DIFF-1:0][COORD_BITS:0]       diff_o
);

  localparam int DW = COORD_BITS + 1;

  logic                                valid_q;
  logic [pic_pkg::NUM_DIFF-1:0][DW-1:0] diff_d, diff_q;
  logic [COORD_BITS-1:0]               ax, ay, bx, by, cx, cy;

  function automatic logic [DW-1:0] sub_ext(input logic [COORD_BITS-1:0] a,
                                            input logic [COORD_BITS-1:0] b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  assign ax = vtx_i[pic_pkg::REG_AX];
  assign ay = vtx_i[pic_pkg::REG_AY];
  assign bx = vtx_i[pic_pkg::REG_BX];
  assign by = vtx_i[pic_pkg::REG_BY];
  assign cx = vtx_i[pic_pkg::REG_CX];
  assign cy = vtx_i[pic_pkg::REG_CY];

  always_comb begin
    diff_d[pic_pkg::D_PAX] = sub_ext(point_x_i, ax);
    diff_d[pic_pkg::D_PAY] = sub_ext(point_y_i, ay);
    diff_d[pic_pkg::D_PBX] = sub_ext(point_x_i, bx);
    diff_d[pic_pkg::D_PBY] = sub_ext(point_y_i, by);
    diff_d[pic_pkg::D_PCX] = sub_ext(point_x_i, cx);
    diff_d[pic_pkg::D_PCY] = sub_ext(point_y_i, cy);
    diff_d[pic_pkg::D_BAX] = sub_ext(bx, ax);
    diff_d[pic_pkg::D_BAY] = sub_ext(by, ay);
    diff_d[pic_pkg::D_CBX] = sub_ext(cx, bx);
    diff_d[pic_pkg::D_CBY] = sub_ext(cy, by);
    diff_d[pic_pkg::D_ACX] = sub_ext(ax, cx);
    diff_d[pic_pkg::D_ACY] = sub_ext(ay, cy);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      diff_q <= diff_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;

endmodule

// ----- design/pic_prod.sv -----
// stage two: one registered signed multiply per product
module pic_prod #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  logic [pic_pkg::NUM_DIFF-1:0][COORD_BITS:0]     diff_i,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output logic [pic_pkg::NUM_PROD-1:0][2*COORD_BITS+1:0] prod_o
);

  localparam int PW = 2 * (COORD_BITS + 1);

  logic                                 valid_q;
  logic [pic_pkg::NUM_PROD-1:0][PW-1:0] prod_d, prod_q;

  always_comb begin
    for (int k = 0; k < pic_pkg::NUM_PROD; k++) begin
      prod_d[k] = $signed(diff_i[pic_pkg::PROD_A[k]]) * $signed(diff_i[pic_pkg::PROD_B[k]]);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ----- design/pic_sum.sv -----
// stage three: crosses, squared lengths and dot products from product pairs
module pic_sum #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  logic [pic_pkg::NUM_PROD-1:0][2*COORD_BITS+1:0] prod_i,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output logic [pic_pkg::NUM_SUM-1:0][2*COORD_BITS+2:0]  sum_o
);

  localparam int PW = 2 * (COORD_BITS + 1);
  localparam int SW = PW + 1;

  logic                                valid_q;
  logic [pic_pkg::NUM_SUM-1:0][SW-1:0] sum_d, sum_q;
  logic [SW-1:0]                       op_a, op_b;

  always_comb begin
    op_a = '0;
    op_b = '0;
    for (int k = 0; k < pic_pkg::NUM_SUM; k++) begin
      op_a = {prod_i[2*k][PW-1], prod_i[2*k]};
      op_b = {prod_i[2*k+1][PW-1], prod_i[2*k+1]};
      sum_d[k] = pic_pkg::SUM_SUB[k] ? (op_a - op_b) : (op_a + op_b);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

// ----- design/pic_class.sv -----
// stages four and five: sign and compare flags, then the location code
module pic_class #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [pic_pkg::NUM_SUM-1:0][2*COORD_BITS+2:0] sum_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [1:0]                                    location_o
);

  localparam int SW = 2 * (COORD_BITS + 1) + 1;

  logic                valid_f_q, valid_l_q;
  logic                ready_f, ready_l;
  pic_pkg::pic_flags_t flags_d, flags_q;
  pic_pkg::pic_loc_e   loc_d, loc_q;
  logic [1:0]          sc0, sc1, sc2;
  logic                z0, z1, z2;
  logic                seg_bc, on_seg, border;

  function automatic logic le_zero(input logic [SW-1:0] v);
    return v[SW-1] || (v == '0);
  endfunction

  // flag stage
  always_comb begin
    flags_d.cr_neg[0]  = sum_i[pic_pkg::S_C1][SW-1];
    flags_d.cr_neg[1]  = sum_i[pic_pkg::S_C2][SW-1];
    flags_d.cr_neg[2]  = sum_i[pic_pkg::S_C3][SW-1];
    flags_d.cr_zero[0] = (sum_i[pic_pkg::S_C1] == '0);
    flags_d.cr_zero[1] = (sum_i[pic_pkg::S_C2] == '0);
    flags_d.cr_zero[2] = (sum_i[pic_pkg::S_C3] == '0);
    flags_d.degen      = (sum_i[pic_pkg::S_DG] == '0);
    flags_d.ab_lt_ac   = $signed(sum_i[pic_pkg::S_LAB]) < $signed(sum_i[pic_pkg::S_LAC]);
    flags_d.ab_lt_bc   = $signed(sum_i[pic_pkg::S_LAB]) < $signed(sum_i[pic_pkg::S_LBC]);
    flags_d.ac_lt_bc   = $signed(sum_i[pic_pkg::S_LAC]) < $signed(sum_i[pic_pkg::S_LBC]);
    flags_d.dot_ab_le  = le_zero(sum_i[pic_pkg::S_DAB]);
    flags_d.dot_ac_le  = le_zero(sum_i[pic_pkg::S_DAC]);
    flags_d.dot_bc_le  = le_zero(sum_i[pic_pkg::S_DBC]);
  end

  // location stage
  always_comb begin
    z0  = flags_q.cr_zero[0];
    z1  = flags_q.cr_zero[1];
    z2  = flags_q.cr_zero[2];
    sc0 = {flags_q.cr_neg[0], z0};
    sc1 = {flags_q.cr_neg[1], z1};
    sc2 = {flags_q.cr_neg[2], z2};
    // longest pair: ab unless ac strictly longer, then bc if strictly longer still
    seg_bc = flags_q.ab_lt_ac ? flags_q.ac_lt_bc : flags_q.ab_lt_bc;
    // the ca edge cross is zero exactly when (p-a)x(c-a) is
    if (seg_bc) begin
      on_seg = z1 && flags_q.dot_bc_le;
    end else if (flags_q.ab_lt_ac) begin
      on_seg = z2 && flags_q.dot_ac_le;
    end else begin
      on_seg = z0 && flags_q.dot_ab_le;
    end
    border = (z0 && sc1 == sc2) || (z1 && sc0 == sc2) || (z2 && sc0 == sc1) ||
             (z0 && z1) || (z0 && z2) || (z1 && z2);
    if (flags_q.degen) begin
      loc_d = on_seg ? pic_pkg::LOC_BORDER : pic_pkg::LOC_OUTSIDE;
    end else if (sc0 == sc1 && sc1 == sc2) begin
      loc_d = pic_pkg::LOC_INSIDE;
    end else if (border) begin
      loc_d = pic_pkg::LOC_BORDER;
    end else begin
      loc_d = pic_pkg::LOC_OUTSIDE;
    end
  end

  assign ready_l = !valid_l_q || ready_i;
  assign ready_f = !valid_f_q || ready_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_f_q <= 1'b0;
      valid_l_q <= 1'b0;
    end else begin
      if (ready_f) begin
        valid_f_q <= valid_i;
      end
      if (ready_l) begin
        valid_l_q <= valid_f_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_f) begin
      flags_q <= flags_d;
    end
    if (valid_f_q && ready_l) begin
      loc_q <= loc_d;
    end
  end

  assign ready_o    = ready_f;
  assign valid_o    = valid_l_q;
  assign location_o = loc_q;

endmodule
